// ----- rtl/core/reply_frame_parser_core_macros.svh -----
// Assertion macros used by the reply frame parser top level.
`ifndef REPLY_FRAME_PARSER_CORE_MACROS_SVH
`define REPLY_FRAME_PARSER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Checks that the consequent holds in the same cycle as the antecedent.
`define RFP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("reply frame parser assertion failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define RFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("reply frame parser assertion failed");
`else
`define RFP_ASSERT_SAME(label, clk, rst, ante, cons)
`define RFP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/rfp_pkg.sv -----
// Types and constants of the reply frame parser.
package rfp_pkg;

   localparam logic [7:0] FRAME_PREFIX  = 8'd88;
   localparam logic [7:0] MAX_BODY_BYTE = 8'd8;
   localparam logic [3:0] MAX_BODY      = 4'd8;
   localparam int         BODY_DEPTH    = 8;

   // Parser phase: hunt for the prefix, read the length, take body and checksum.
   typedef enum logic [1:0] {
      PH_HUNT   = 2'd0,
      PH_LENGTH = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   // Contents of the input register.
   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } byte_slot_type;

   // Parser status seen by the top level.
   typedef struct packed {
      phase_type  phase;
      logic [3:0] body_idx;
      logic [3:0] body_len;
      logic       take;
   } engine_status_type;

   // One result of a completed frame.
   typedef struct packed {
      logic       checksum_ok;
      logic [3:0] body_length;
      logic [7:0] version_byte;
      logic [7:0] completion_code;
      logic [7:0] command_code;
      logic [7:0] payload_a;
      logic [7:0] payload_b;
      logic [7:0] payload_c;
      logic [7:0] payload_d;
      logic [7:0] payload_e;
   } result_type;

endpackage

// ----- rtl/core/rfp_stream_if.sv -----
// Request and response channel interfaces of the reply frame parser.
interface rfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface rfp_rsp_if;
   logic       valid;
   logic       ready;
   logic       checksum_ok;
   logic [3:0] body_length;
   logic [7:0] version_byte;
   logic [7:0] completion_code;
   logic [7:0] command_code;
   logic [7:0] payload_a;
   logic [7:0] payload_b;
   logic [7:0] payload_c;
   logic [7:0] payload_d;
   logic [7:0] payload_e;

   modport source (
      output valid, output checksum_ok, output body_length, output version_byte,
      output completion_code, output command_code, output payload_a,
      output payload_b, output payload_c, output payload_d, output payload_e,
      input ready
   );
   modport sink (
      input valid, input checksum_ok, input body_length, input version_byte,
      input completion_code, input command_code, input payload_a,
      input payload_b, input payload_c, input payload_d, input payload_e,
      output ready
   );
endinterface

// ----- rtl/core/rfp_in_reg.sv -----
// Input register that holds one received byte until the parser takes it.
module rfp_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [7:0]            req_rx_byte,
   output logic                  req_ready,
   input  logic                  take,
   output rfp_pkg::byte_slot_type slot
);
   import rfp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       accept;

   // The register can load whenever it is empty or is being drained.
   assign req_ready = !valid_ff || take;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (accept) begin
         valid_in = 1'b1;
         byte_in  = req_rx_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign slot.valid   = valid_ff;
   assign slot.rx_byte = byte_ff;

endmodule

// ----- rtl/core/rfp_engine.sv -----
// Frame parser state, body store, running XOR and result register.
module rfp_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  rfp_pkg::byte_slot_type    slot,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output rfp_pkg::result_type       rsp_data,
   output rfp_pkg::engine_status_type status
);
   import rfp_pkg::*;

   phase_type  phase_ff;
   phase_type  phase_in;
   logic [3:0] idx_ff;
   logic [3:0] idx_in;
   logic [3:0] len_ff;
   logic [3:0] len_in;
   logic [7:0] xor_ff;
   logic [7:0] xor_in;
   logic [7:0] store_ff [BODY_DEPTH];
   logic [7:0] store_in [BODY_DEPTH];
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_data_ff;
   result_type out_data_in;
   logic       out_free;
   logic       take;
   logic       in_body;
   logic [7:0] rx;

   // A byte is processed only when the result register can take a result.
   assign out_free = !out_valid_ff || rsp_ready;
   assign take     = slot.valid && out_free;
   assign rx       = slot.rx_byte;
   assign in_body  = idx_ff < len_ff;

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (rx == FRAME_PREFIX) phase_in = PH_LENGTH;
            end
            PH_LENGTH: begin
               phase_in = (rx > MAX_BODY_BYTE) ? PH_HUNT : PH_BODY;
            end
            PH_BODY: begin
               if (!in_body) phase_in = PH_HUNT;
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   // Length, body index, store, XOR and result.
   always_comb begin
      idx_in       = idx_ff;
      len_in       = len_ff;
      xor_in       = xor_ff;
      store_in     = store_ff;
      out_valid_in = out_free ? 1'b0 : out_valid_ff;
      out_data_in  = out_data_ff;
      if (take) begin
         unique case (phase_ff)
            PH_HUNT: begin
            end
            PH_LENGTH: begin
               if (rx <= MAX_BODY_BYTE) begin
                  len_in = rx[3:0];
                  idx_in = 4'd0;
                  xor_in = 8'd0;
               end
            end
            PH_BODY: begin
               if (in_body) begin
                  store_in[idx_ff[2:0]] = rx;
                  xor_in = xor_ff ^ rx;
                  idx_in = idx_ff + 4'd1;
               end else begin
                  // Checksum byte: compare and report the whole store.
                  out_valid_in                = 1'b1;
                  out_data_in.checksum_ok     = (xor_ff == rx);
                  out_data_in.body_length     = len_ff;
                  out_data_in.version_byte    = store_ff[0];
                  out_data_in.completion_code = store_ff[1];
                  out_data_in.command_code    = store_ff[2];
                  out_data_in.payload_a       = store_ff[3];
                  out_data_in.payload_b       = store_ff[4];
                  out_data_in.payload_c       = store_ff[5];
                  out_data_in.payload_d       = store_ff[6];
                  out_data_in.payload_e       = store_ff[7];
                  xor_in                      = 8'd0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         idx_ff       <= 4'd0;
         len_ff       <= 4'd0;
         xor_ff       <= 8'd0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < BODY_DEPTH; i++) begin
            store_ff[i] <= 8'd0;
         end
      end else begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         len_ff       <= len_in;
         xor_ff       <= xor_in;
         out_valid_ff <= out_valid_in;
         store_ff     <= store_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_data        = out_data_ff;
   assign status.phase    = phase_ff;
   assign status.body_idx = idx_ff;
   assign status.body_len = len_ff;
   assign status.take     = take;

endmodule

// ----- rtl/core/reply_frame_parser_core.sv -----
// Top level of the reply frame parser: input register, parser and result register.
//
// The request channel carries one received serial byte per request. The
// parser hunts for the prefix byte 88, reads a length byte (0 to 8; any
// larger value returns it to the hunt), stores that many body bytes and then
// compares the XOR of the body with the following checksum byte. The
// checksum byte produces one response carrying the check flag, the body
// length and all eight body store bytes; positions the frame did not write
// keep their earlier values. All other bytes produce no response.
// The checksum byte waits in the input register and is then parsed into the
// result register, which drives the response.
// Throughput: one request per cycle while responses are taken; the parser
// state updates once per byte. Reset clears the parser phase, length,
// running XOR, the body store and the valid flags of both registers. When
// the response receiver stalls, the pending response is held and the parser
// takes no byte at all, so the input register fills and request ready drops
// until the response is taken.
`include "reply_frame_parser_core_macros.svh"
module reply_frame_parser_core (
   input logic  clock,
   input logic  reset,
   rfp_req_if.sink   req_chan,
   rfp_rsp_if.source rsp_chan
);
   import rfp_pkg::*;

   byte_slot_type     slot;
   engine_status_type status;
   result_type        rsp_data;
   logic              rsp_valid;

   // Input register.
   rfp_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_rx_byte (req_chan.rx_byte),
      .req_ready   (req_chan.ready),
      .take        (status.take),
      .slot        (slot)
   );

   // Parser and result register.
   rfp_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .slot      (slot),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .status    (status)
   );

   // Response channel outputs.
   assign rsp_chan.valid           = rsp_valid;
   assign rsp_chan.checksum_ok     = rsp_data.checksum_ok;
   assign rsp_chan.body_length     = rsp_data.body_length;
   assign rsp_chan.version_byte    = rsp_data.version_byte;
   assign rsp_chan.completion_code = rsp_data.completion_code;
   assign rsp_chan.command_code    = rsp_data.command_code;
   assign rsp_chan.payload_a       = rsp_data.payload_a;
   assign rsp_chan.payload_b       = rsp_data.payload_b;
   assign rsp_chan.payload_c       = rsp_data.payload_c;
   assign rsp_chan.payload_d       = rsp_data.payload_d;
   assign rsp_chan.payload_e       = rsp_data.payload_e;

   // The stored length never exceeds the body store, nor the index the length.
   `RFP_ASSERT_SAME(a_len_bound, clock, reset, 1'b1, status.body_len <= MAX_BODY)
   `RFP_ASSERT_SAME(a_idx_bound, clock, reset, 1'b1, status.body_idx <= status.body_len)
   // A byte taken while no new request arrives empties the input register.
   `RFP_ASSERT_NEXT(a_drain, clock, reset,
      status.take && !req_chan.valid, !slot.valid)
   // A new response only follows a body-phase byte whose index reached the length.
   `RFP_ASSERT_NEXT(a_rsp_source, clock, reset,
      status.take && !(status.phase == PH_BODY && status.body_idx == status.body_len),
      !rsp_chan.valid || $past(rsp_chan.valid) && !$past(rsp_chan.ready))

endmodule

// ----- bench/tb_reply_frame_parser_core.sv -----
// Self-checking testbench for the reply frame parser core.
`timescale 1ns / 1ps

module tb_reply_frame_parser_core;
   import rfp_pkg::*;

   localparam int RANDOM_BYTES = 700;
   localparam int QUIET_TAIL   = 80;
   localparam int LONG_HOLD    = 150;
   localparam int IDLE_LIMIT   = 2000;

   logic clock;
   logic reset;

   rfp_req_if req_bus ();
   rfp_rsp_if rsp_bus ();

   reply_frame_parser_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Bytes still to be sent and frame reports still to arrive.
   logic [7:0] pending_bytes[$];
   result_type expected_frames[$];

   // Parser state as the testbench sees it.
   phase_type  parse_phase;
   logic [3:0] body_pos;
   logic [3:0] body_len;
   logic [7:0] body_mem[BODY_DEPTH];
   logic [7:0] xor_acc;

   int  mismatch_count;
   int  req_count;
   int  rsp_count;
   int  frame_count;
   int  good_sum_count;
   int  reject_count;
   int  req_gap;
   int  rsp_gap;
   int  req_idle_pct;
   int  rsp_idle_pct;
   int  idle_cycles;
   int  hold_cycles;
   bit  long_hold;
   bit  long_hold_done;
   bit  quiet_tail;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Advances the parser state by one received byte and queues any frame report.
   task automatic parse_rx_byte(input logic [7:0] rx);
      result_type frame_res;
      case (parse_phase)
         PH_HUNT: begin
            if (rx == FRAME_PREFIX) parse_phase = PH_LENGTH;
         end
         PH_LENGTH: begin
            if (rx > MAX_BODY_BYTE) begin
               parse_phase = PH_HUNT;
               reject_count++;
            end else begin
               body_len    = rx[3:0];
               body_pos    = 4'd0;
               xor_acc     = 8'd0;
               parse_phase = PH_BODY;
            end
         end
         default: begin
            if (body_pos < body_len) begin
               body_mem[body_pos] = rx;
               xor_acc            = xor_acc ^ rx;
               body_pos           = body_pos + 4'd1;
            end else begin
               // The checksum byte closes the frame and is never stored.
               frame_res.checksum_ok     = (xor_acc == rx);
               frame_res.body_length     = body_len;
               frame_res.version_byte    = body_mem[0];
               frame_res.completion_code = body_mem[1];
               frame_res.command_code    = body_mem[2];
               frame_res.payload_a       = body_mem[3];
               frame_res.payload_b       = body_mem[4];
               frame_res.payload_c       = body_mem[5];
               frame_res.payload_d       = body_mem[6];
               frame_res.payload_e       = body_mem[7];
               expected_frames.push_back(frame_res);
               if (frame_res.checksum_ok) good_sum_count++;
               frame_count++;
               parse_phase = PH_HUNT;
               xor_acc     = 8'd0;
            end
         end
      endcase
   endtask

   // Queues one complete frame with a random body.
   task automatic queue_frame(input int len, input bit good_sum);
      logic [7:0] sum;
      logic [7:0] b;
      sum = 8'd0;
      pending_bytes.push_back(FRAME_PREFIX);
      pending_bytes.push_back(8'(len));
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom_range(0, 255));
         sum ^= b;
         pending_bytes.push_back(b);
      end
      pending_bytes.push_back(good_sum ? sum : 8'($urandom_range(0, 255)));
   endtask

   function automatic void check_field(input string field_name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, field_name, want, got);
         mismatch_count++;
      end
   endfunction

   // Request driver: offers queued bytes, with random idle bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap      = 0;
         req_idle_pct = 25;
         parse_phase  = PH_HUNT;
         body_pos     = 4'd0;
         body_len     = 4'd0;
         xor_acc      = 8'd0;
         for (int i = 0; i < BODY_DEPTH; i++) body_mem[i] = 8'd0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            parse_rx_byte(req_bus.rx_byte);
            void'(pending_bytes.pop_front());
            req_count++;
            if (req_count % 64 == 0) req_idle_pct = 15 * $urandom_range(0, 3);
         end
         quiet_tail <= (pending_bytes.size() < QUIET_TAIL);
         if (req_bus.valid && !req_bus.ready) begin
            // Keep offering the same request until it is taken.
            req_bus.valid <= 1'b1;
         end else if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_bytes.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 99) < req_idle_pct) begin
            req_gap = $urandom_range(1, 6) - 1;
            req_bus.valid <= 1'b0;
         end else begin
            req_bus.valid   <= 1'b1;
            req_bus.rx_byte <= pending_bytes[0];
         end
      end
   end

   // One long receiver stall, counted here while the sender keeps offering.
   always @(posedge clock) begin
      if (reset) begin
         hold_cycles = 0;
         long_hold  <= 1'b0;
      end else if (long_hold) begin
         hold_cycles++;
         if (hold_cycles >= LONG_HOLD) long_hold <= 1'b0;
      end else if (!long_hold_done && rsp_count >= 20) begin
         long_hold_done = 1'b1;
         hold_cycles    = 0;
         long_hold     <= 1'b1;
      end
   end

   // Response monitor: checks each report and applies back-pressure.
   always @(posedge clock) begin
      result_type got;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_gap      = 0;
         rsp_idle_pct = 25;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.checksum_ok     = rsp_bus.checksum_ok;
            got.body_length     = rsp_bus.body_length;
            got.version_byte    = rsp_bus.version_byte;
            got.completion_code = rsp_bus.completion_code;
            got.command_code    = rsp_bus.command_code;
            got.payload_a       = rsp_bus.payload_a;
            got.payload_b       = rsp_bus.payload_b;
            got.payload_c       = rsp_bus.payload_c;
            got.payload_d       = rsp_bus.payload_d;
            got.payload_e       = rsp_bus.payload_e;
            if (expected_frames.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual body_length %0d",
                        $time, got.body_length);
               mismatch_count++;
            end else begin
               check_field("checksum_ok", 8'(expected_frames[0].checksum_ok),
                           8'(got.checksum_ok));
               check_field("body_length", 8'(expected_frames[0].body_length),
                           8'(got.body_length));
               check_field("version_byte", expected_frames[0].version_byte,
                           got.version_byte);
               check_field("completion_code", expected_frames[0].completion_code,
                           got.completion_code);
               check_field("command_code", expected_frames[0].command_code,
                           got.command_code);
               check_field("payload_a", expected_frames[0].payload_a, got.payload_a);
               check_field("payload_b", expected_frames[0].payload_b, got.payload_b);
               check_field("payload_c", expected_frames[0].payload_c, got.payload_c);
               check_field("payload_d", expected_frames[0].payload_d, got.payload_d);
               check_field("payload_e", expected_frames[0].payload_e, got.payload_e);
               void'(expected_frames.pop_front());
            end
            rsp_count++;
            if (rsp_count % 8 == 0) rsp_idle_pct = 15 * $urandom_range(0, 3);
         end
         if (long_hold) begin
            // The long stall lets the parser back up and drop request ready.
            rsp_bus.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_gap = $urandom_range(1, 6) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, %0d bytes and %0d reports outstanding", $time,
                     pending_bytes.size(), expected_frames.size());
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      int total;
      int pick;
      int len;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = 8'd0;
      rsp_bus.ready   = 1'b0;
      mismatch_count  = 0;
      req_count       = 0;
      rsp_count       = 0;
      frame_count     = 0;
      good_sum_count  = 0;
      reject_count    = 0;
      long_hold_done  = 1'b0;
      quiet_tail      = 1'b0;

      // Noise while hunting, then an empty frame with a good checksum.
      pending_bytes.push_back(8'hFF);
      pending_bytes.push_back(FRAME_PREFIX);
      pending_bytes.push_back(8'd0);
      pending_bytes.push_back(8'd0);
      // A prefix used as a length is rejected and not taken as a new prefix.
      pending_bytes.push_back(FRAME_PREFIX);
      pending_bytes.push_back(FRAME_PREFIX);
      pending_bytes.push_back(8'd2);
      // Lengths just over the limit and at the top of the byte range.
      pending_bytes.push_back(FRAME_PREFIX);
      pending_bytes.push_back(8'd9);
      pending_bytes.push_back(FRAME_PREFIX);
      pending_bytes.push_back(8'd255);
      // Full frame with a walking one body and a correct checksum.
      pending_bytes.push_back(FRAME_PREFIX);
      pending_bytes.push_back(8'd8);
      for (int i = 0; i < 8; i++) pending_bytes.push_back(8'(1 << i));
      pending_bytes.push_back(8'hFF);
      // Short frame with a bad checksum; the upper positions stay stale.
      pending_bytes.push_back(FRAME_PREFIX);
      pending_bytes.push_back(8'd2);
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hFF);
      pending_bytes.push_back(8'h00);

      // Random part: mostly well-formed frames, some noise and broken frames.
      total = pending_bytes.size() + RANDOM_BYTES;
      while (pending_bytes.size() < total) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            queue_frame($urandom_range(0, 8), $urandom_range(0, 3) != 0);
         end else if (pick < 85) begin
            pending_bytes.push_back(8'($urandom_range(0, 255)));
         end else if (pick < 93) begin
            pending_bytes.push_back(FRAME_PREFIX);
            pending_bytes.push_back(8'($urandom_range(9, 255)));
         end else begin
            // Truncated frame: the next frame's bytes land in its body.
            len = $urandom_range(1, 8);
            pending_bytes.push_back(FRAME_PREFIX);
            pending_bytes.push_back(8'(len));
            for (int i = 0; i < $urandom_range(0, len - 1); i++)
               pending_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0) @(posedge clock);
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (expected_frames.size() != 0) begin
         $display("%0t: %0d reports expected, none arrived", $time, expected_frames.size());
         mismatch_count++;
      end
      $display("Sent %0d bytes; %0d frames completed, %0d with a good checksum.",
               req_count, frame_count, good_sum_count);
      $display("Rejected lengths: %0d; responses checked: %0d.", reject_count, rsp_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/rfp_pkg.sv
rtl/core/rfp_stream_if.sv
rtl/core/rfp_in_reg.sv
rtl/core/rfp_engine.sv
rtl/core/reply_frame_parser_core.sv
bench/tb_reply_frame_parser_core.sv
